// File: hw/rtl/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and character constants for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Request kinds
  localparam logic       KIND_BYTE      = 1'b0;
  localparam logic       KIND_END       = 1'b1;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CTRL_LIMIT     = 8'd32;

  // Escape class of one request, decided by the front end
  typedef enum logic [1:0] {
    CLS_PLAIN,  // byte passes through
    CLS_PAIR,   // backslash then the byte in data
    CLS_UHEX,   // \u00 then two hex digits of data
    CLS_CLOSE   // closing quote
  } jse_class_t;

  typedef struct packed {
    logic       open_quote;  // emit an opening quote first
    jse_class_t cls;
    logic [7:0] data;
  } jse_desc_t;

  // Width of the index of a result byte within one request (up to seven bytes)
  localparam int unsigned STEP_W = 3;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'b0000, nib};
    end else begin
      ch = CHAR_LOWER_A + {4'b0000, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/jse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_front
// Accepts input requests, classifies each byte and tracks the open string.
// ----------------------------------------------------------------------------
module jse_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire              kind,
  input  wire [7:0]        char_byte,
  output jse_pkg::jse_desc_t desc
);
  import jse_pkg::*;

  logic inside_string;
  logic is_end;

  assign is_end = (kind == KIND_END) || (char_byte == CHAR_NUL);

  always_comb begin
    desc.open_quote = !inside_string;
    desc.data       = char_byte;
    desc.cls        = CLS_PLAIN;
    if (is_end) begin
      desc.cls = CLS_CLOSE;
    end else begin
      unique case (char_byte)
        CHAR_QUOTE:     desc.cls = CLS_PAIR;
        CHAR_BACKSLASH: desc.cls = CLS_PAIR;
        CHAR_NEWLINE: begin
          desc.cls  = CLS_PAIR;
          desc.data = CHAR_LOWER_N;
        end
        CHAR_CR: begin
          desc.cls  = CLS_PAIR;
          desc.data = CHAR_LOWER_R;
        end
        CHAR_TAB: begin
          desc.cls  = CLS_PAIR;
          desc.data = CHAR_LOWER_T;
        end
        default: begin
          if (char_byte < CTRL_LIMIT) begin
            desc.cls = CLS_UHEX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string <= 1'b0;
    end else if (push) begin
      inside_string <= !is_end;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jse_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_queue
// Small FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module jse_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  jse_pkg::jse_desc_t push_desc,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output jse_pkg::jse_desc_t head_desc
);
  import jse_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jse_desc_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_back
// Expands the head request into output bytes, one per cycle while the
// receiver does not stall, into the output register.
// ----------------------------------------------------------------------------
module jse_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                head_valid,
  input  jse_pkg::jse_desc_t head_desc,
  output logic               pop,
  output logic               result_valid,
  input  wire                result_stall,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);
  import jse_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [STEP_W-1:0] body_idx;
  logic [STEP_W-1:0] body_last;
  logic [7:0]        body_byte;
  logic [7:0]        cur_byte;
  logic              is_last;
  logic              can_load;
  logic              fire;

  assign can_load = !result_valid || !result_stall;
  assign fire     = can_load && head_valid;
  assign body_idx = step - {{(STEP_W-1){1'b0}}, head_desc.open_quote};

  always_comb begin
    body_byte = head_desc.data;
    body_last = '0;
    unique case (head_desc.cls)
      CLS_PLAIN: begin
        body_byte = head_desc.data;
        body_last = STEP_W'(0);
      end
      CLS_PAIR: begin
        body_byte = (body_idx == STEP_W'(0)) ? CHAR_BACKSLASH : head_desc.data;
        body_last = STEP_W'(1);
      end
      CLS_UHEX: begin
        body_last = STEP_W'(5);
        case (body_idx)
          STEP_W'(0): body_byte = CHAR_BACKSLASH;
          STEP_W'(1): body_byte = CHAR_LOWER_U;
          STEP_W'(2): body_byte = CHAR_ZERO;
          STEP_W'(3): body_byte = CHAR_ZERO;
          STEP_W'(4): body_byte = hex_digit(head_desc.data[7:4]);
          default:    body_byte = hex_digit(head_desc.data[3:0]);
        endcase
      end
      CLS_CLOSE: begin
        body_byte = CHAR_QUOTE;
        body_last = STEP_W'(0);
      end
      default: begin
        body_byte = head_desc.data;
        body_last = STEP_W'(0);
      end
    endcase
  end

  // Opening quote comes ahead of the body
  assign cur_byte  = (head_desc.open_quote && step == '0) ? CHAR_QUOTE : body_byte;
  assign is_last   = !(head_desc.open_quote && step == '0) && (body_idx == body_last);
  assign pop       = fire && is_last;
  assign step_next = fire ? (is_last ? '0 : step + 1'b1) : step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (can_load) begin
        result_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= cur_byte;
      last_of_run <= is_last;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/json_string_escaper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_escaper_core
// Streams string bytes out as quoted, escaped JSON string text.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  item      item_valid / item_stall      kind, char_byte
//  result    result_valid / result_stall  out_byte, last_of_run
//
//  One request is taken per cycle while the queue has room; it yields one to
//  seven result bytes, and the back end emits one byte per cycle unless result_stall holds it.
//  A request is first written to the queue, then loaded into the output register.
//  An escape holds its queue entry while its bytes go out, so the input
//  stalls once QUEUE_DEPTH requests are waiting.
//  Reset clears the open-string flag, the queue pointers and count, and the output valid flag.
// ----------------------------------------------------------------------------
module json_string_escaper_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        item_valid,
  output logic       item_stall,
  input  wire        kind,
  input  wire [7:0]  char_byte,
  output logic       result_valid,
  input  wire        result_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import jse_pkg::*;

  jse_desc_t front_desc;
  jse_desc_t head_desc;
  logic      push;
  logic      pop;
  logic      full;
  logic      head_valid;

  assign item_stall = full;
  assign push       = item_valid && !item_stall;

  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .char_byte (char_byte),
    .desc      (front_desc)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (front_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  jse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_desc    (head_desc),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> head_valid)
    else $error("queue empty after a request was taken");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> head_valid)
    else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

// File: bench/jse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_checker
// Watches the request and result channels of the JSON string escaper. It
// rebuilds the quoted, escaped text of every accepted request in a queue and
// compares each accepted result byte and its last-of-run flag against it.
// ----------------------------------------------------------------------------
module jse_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        item_valid,
  input  wire        item_stall,
  input  wire        kind,
  input  wire [7:0]  char_byte,
  input  wire        result_valid,
  input  wire        result_stall,
  input  wire [7:0]  out_byte,
  input  wire        last_of_run,
  output int         mismatches,
  output int         backlog
);
  import jse_pkg::*;

  localparam int         REPORT_MAX = 10;
  // Character '0' sits in the lowest byte
  localparam logic [127:0] HEX_CHARS = "fedcba9876543210";

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_byte_t;

  text_byte_t awaited_text[$];
  logic       string_open;
  int         result_index;

  initial begin
    mismatches   = 0;
    backlog      = 0;
    result_index = 0;
    string_open  = 1'b0;
  end

  function automatic void push_text(input logic [7:0] c);
    awaited_text.push_back('{text: c, last: 1'b0});
  endfunction

  function automatic void escape_request(input logic k, input logic [7:0] c);
    if (!string_open) begin
      push_text(CHAR_QUOTE);
    end
    if (k == KIND_END || c == CHAR_NUL) begin
      push_text(CHAR_QUOTE);
      string_open = 1'b0;
    end else begin
      string_open = 1'b1;
      case (c)
        CHAR_QUOTE, CHAR_BACKSLASH: begin
          push_text(CHAR_BACKSLASH);
          push_text(c);
        end
        CHAR_NEWLINE: begin
          push_text(CHAR_BACKSLASH);
          push_text(CHAR_LOWER_N);
        end
        CHAR_CR: begin
          push_text(CHAR_BACKSLASH);
          push_text(CHAR_LOWER_R);
        end
        CHAR_TAB: begin
          push_text(CHAR_BACKSLASH);
          push_text(CHAR_LOWER_T);
        end
        default: begin
          if (c < CTRL_LIMIT) begin
            push_text(CHAR_BACKSLASH);
            push_text(CHAR_LOWER_U);
            push_text(CHAR_ZERO);
            push_text(CHAR_ZERO);
            push_text(HEX_CHARS[{c[7:4], 3'b000} +: 8]);
            push_text(HEX_CHARS[{c[3:0], 3'b000} +: 8]);
          end else begin
            push_text(c);
          end
        end
      endcase
    end
    awaited_text[awaited_text.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    text_byte_t want;
    if (rst) begin
      awaited_text.delete();
      string_open = 1'b0;
    end else begin
      // Compare before predicting: a result never belongs to a request taken at this edge
      if (result_valid && !result_stall) begin
        if (awaited_text.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("result %0d unexpected: byte %02h last %0b",
                     result_index, out_byte, last_of_run);
          end
          mismatches++;
        end else begin
          want = awaited_text.pop_front();
          if (want.text !== out_byte || want.last !== last_of_run) begin
            if (mismatches < REPORT_MAX) begin
              $display("result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       result_index, want.text, want.last, out_byte, last_of_run);
            end
            mismatches++;
          end
        end
        result_index++;
      end
      if (item_valid && !item_stall) begin
        escape_request(kind, char_byte);
      end
    end
    backlog = awaited_text.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the JSON string escaper with directed strings covering every escape
// class and the empty-string and longest-run cases, then with random strings
// under random idling on both sides, a long receiver hold-off and a drain
// pause. Checking is done by jse_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import jse_pkg::*;

  localparam int         MAX_GAP      = 11;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS = 66;
  localparam int         DRAIN_CYCLES = 20;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       kind         = KIND_BYTE;
  logic [7:0] char_byte    = CHAR_NUL;
  logic       result_stall = 1'b0;
  wire        item_stall;
  wire        result_valid;
  wire [7:0]  out_byte;
  wire        last_of_run;

  int mismatches;
  int backlog;
  int idle_cycles = 0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_escaper_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  jse_checker text_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .mismatches   (mismatches),
    .backlog      (backlog)
  );

  task automatic send_request(input logic k, input logic [7:0] c);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    char_byte  <= c;
    do @(posedge clk); while (item_stall);
  endtask

  // Hold off until every awaited result byte has gone out
  task automatic await_drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'($urandom_range(8'h20, 8'h7E));
      4: begin
        case ($urandom_range(0, 4))
          0:       c = CHAR_QUOTE;
          1:       c = CHAR_BACKSLASH;
          2:       c = CHAR_NEWLINE;
          3:       c = CHAR_CR;
          default: c = CHAR_TAB;
        endcase
      end
      5, 6:    c = 8'($urandom_range(1, 31));
      7, 8:    c = 8'($urandom_range(128, 255));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  initial begin : receiver
    int wait_cycles;
    forever begin
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if ($urandom_range(0, 15) == 0) begin
          recv_calm = !recv_calm;
        end
        wait_cycles = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (wait_cycles > 0) begin
          result_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty strings: end request with ignored payload, then a zero byte
    send_request(KIND_END, 8'hFF);
    send_request(KIND_BYTE, CHAR_NUL);
    // Opening quote plus a six-byte unicode escape
    send_request(KIND_BYTE, 8'h1F);
    send_request(KIND_BYTE, CHAR_QUOTE);
    send_request(KIND_BYTE, CHAR_BACKSLASH);
    send_request(KIND_BYTE, CHAR_NEWLINE);
    send_request(KIND_BYTE, CHAR_CR);
    send_request(KIND_BYTE, CHAR_TAB);
    send_request(KIND_BYTE, 8'h01);
    send_request(KIND_BYTE, 8'h1B);
    send_request(KIND_BYTE, 8'h20);
    send_request(KIND_BYTE, 8'h7E);
    send_request(KIND_BYTE, 8'h7F);
    send_request(KIND_BYTE, 8'h80);
    send_request(KIND_BYTE, 8'hFF);
    send_request(KIND_END, CHAR_NUL);
    send_request(KIND_BYTE, CHAR_QUOTE);
    send_request(KIND_BYTE, CHAR_NUL);
    send_request(KIND_BYTE, 8'h41);
    send_request(KIND_END, 8'hAA);
    send_request(KIND_BYTE, CHAR_TAB);
    send_request(KIND_END, 8'h55);
    await_drain();

    // Receiver holds off while requests keep coming back to back
    hold_request = 1'b1;
    send_calm    = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_request(KIND_BYTE, pick_char());
    end
    send_request(KIND_END, CHAR_NUL);
    send_calm = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        send_calm = !send_calm;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Stray end request
        send_request(KIND_END, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          send_request(KIND_BYTE, pick_char());
          sent++;
        end
        if ($urandom_range(0, 1) == 1) begin
          send_request(KIND_END, 8'($urandom_range(0, 255)));
        end else begin
          send_request(KIND_BYTE, CHAR_NUL);
        end
        sent++;
      end
      if ($urandom_range(0, 24) == 0) begin
        await_drain();
      end
    end

    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
